[design/qr_segment_bit_packer_core_defines.svh]
// Assertion macros used by the file that checks the packer.
`ifndef QR_SEGMENT_BIT_PACKER_CORE_DEFINES_SVH
`define QR_SEGMENT_BIT_PACKER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QSBP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qsbp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define QSBP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qsbp assertion failed");

`endif

[design/qsbp_pkg.sv]
package qsbp_pkg;

  typedef enum logic {
    OP_START  = 1'b0,
    OP_SYMBOL = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    MODE_NUMERIC = 2'd0,
    MODE_ALNUM   = 2'd1,
    MODE_BYTE    = 2'd2,
    MODE_KANJI   = 2'd3
  } mode_e;

  localparam logic [15:0] KANJI_LO1   = 16'h8140;
  localparam logic [15:0] KANJI_HI1   = 16'h9FFC;
  localparam logic [15:0] KANJI_LO2   = 16'hE040;
  localparam logic [15:0] KANJI_HI2   = 16'hEBBF;
  localparam logic [15:0] KANJI_OFS2  = 16'hC140;
  localparam logic [15:0] KANJI_ROW   = 16'h00C0;
  localparam logic [15:0] ALNUM_MAX   = 16'd44;
  localparam logic [15:0] DIGIT_MAX   = 16'd9;
  localparam logic [10:0] ALNUM_RADIX = 11'd45;
  localparam logic [9:0]  DIGIT_RADIX = 10'd10;

  localparam logic [4:0] W_MAX        = 5'd16;
  localparam logic [4:0] W_DIGIT3     = 5'd10;
  localparam logic [4:0] W_DIGIT2     = 5'd7;
  localparam logic [4:0] W_DIGIT1     = 5'd4;
  localparam logic [4:0] W_ALNUM2     = 5'd11;
  localparam logic [4:0] W_ALNUM1     = 5'd6;
  localparam logic [4:0] W_BYTE       = 5'd8;
  localparam logic [4:0] W_KANJI      = 5'd13;
  localparam logic [1:0] FILL_FULL    = 2'd3;
  localparam logic [1:0] FILL_TWO     = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [1:0]  mode;
    logic [15:0] char_count;
    logic [4:0]  count_bits;
    logic [15:0] symbol;
  } item_t;

  typedef struct packed {
    logic [15:0] chunk_value;
    logic [4:0]  chunk_width;
    logic        last_chunk;
    logic        error;
  } result_t;

  typedef struct packed {
    logic [1:0]  seg_mode;
    logic [15:0] remaining;
    logic [6:0]  group_acc;
    logic [1:0]  group_fill;
  } state_t;

  function automatic logic [15:0] chunk_mask(input logic [4:0] width);
    logic [4:0] sh;
    if (width >= W_MAX) begin
      sh = 5'd0;
    end else begin
      sh = W_MAX - width;
    end
    return 16'hFFFF >> sh;
  endfunction

endpackage

[design/qsbp_if.sv]
interface qsbp_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [1:0]  mode;
  logic [15:0] char_count;
  logic [4:0]  count_bits;
  logic [15:0] symbol;

  modport source (output valid, operation, mode, char_count, count_bits, symbol,
                  input ready);
  modport sink (input valid, operation, mode, char_count, count_bits, symbol,
                output ready);
endinterface

interface qsbp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] chunk_value;
  logic [4:0]  chunk_width;
  logic        last_chunk;
  logic        error;

  modport source (output valid, chunk_value, chunk_width, last_chunk, error,
                  input ready);
  modport sink (input valid, chunk_value, chunk_width, last_chunk, error,
                output ready);
endinterface

[design/qsbp_in_reg.sv]
module qsbp_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  qsbp_in_if.sink        in_i,
  input  logic           advance_i,
  output logic           valid_o,
  output qsbp_pkg::item_t item_o
);

  logic            valid_q;
  qsbp_pkg::item_t item_q;
  qsbp_pkg::item_t item_d;
  logic            take;

  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    item_d.operation  = in_i.operation;
    item_d.mode       = in_i.mode;
    item_d.char_count = in_i.char_count;
    item_d.count_bits = in_i.count_bits;
    item_d.symbol     = in_i.symbol;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[design/qsbp_encoder.sv]
module qsbp_encoder (
  input  qsbp_pkg::item_t   item_i,
  input  qsbp_pkg::state_t  state_i,
  output qsbp_pkg::state_t  state_o,
  output qsbp_pkg::result_t result_o,
  output logic              has_result_o
);

  always_comb begin
    logic [4:0]  hdr_w;
    logic [15:0] raw;
    logic [15:0] sym;
    logic [15:0] rem_n;
    logic [1:0]  fill_n;
    logic [9:0]  num_val;
    logic [10:0] aln_val;
    logic [15:0] adj;
    logic [15:0] kan_val;
    logic        bad;

    sym     = item_i.symbol;
    rem_n   = state_i.remaining - 16'd1;
    fill_n  = state_i.group_fill + 2'd1;
    num_val = 10'(state_i.group_acc) * qsbp_pkg::DIGIT_RADIX + 10'(sym[3:0]);
    aln_val = 11'(state_i.group_acc) * qsbp_pkg::ALNUM_RADIX + 11'(sym[5:0]);
    adj     = (sym <= qsbp_pkg::KANJI_HI1) ? (sym - qsbp_pkg::KANJI_LO1)
                                           : (sym - qsbp_pkg::KANJI_OFS2);
    kan_val = 16'(adj[15:8]) * qsbp_pkg::KANJI_ROW + 16'(adj[7:0]);
    hdr_w   = (item_i.count_bits > qsbp_pkg::W_MAX) ? qsbp_pkg::W_MAX : item_i.count_bits;
    bad     = 1'b0;

    state_o                = state_i;
    has_result_o           = 1'b0;
    raw                    = 16'd0;
    result_o.chunk_width   = 5'd0;
    result_o.last_chunk    = 1'b0;
    result_o.error         = 1'b0;

    if (item_i.operation == qsbp_pkg::OP_START) begin
      state_o.seg_mode   = item_i.mode;
      state_o.remaining  = item_i.char_count;
      state_o.group_acc  = 7'd0;
      state_o.group_fill = 2'd0;
      has_result_o         = 1'b1;
      raw                  = item_i.char_count;
      result_o.chunk_width = hdr_w;
      result_o.last_chunk  = (item_i.char_count == 16'd0);
    end else if (state_i.remaining != 16'd0) begin
      case (state_i.seg_mode)
        qsbp_pkg::MODE_NUMERIC: begin
          if (sym > qsbp_pkg::DIGIT_MAX) begin
            bad = 1'b1;
          end else begin
            state_o.remaining = rem_n;
            if (fill_n == qsbp_pkg::FILL_FULL) begin
              state_o.group_acc    = 7'd0;
              state_o.group_fill   = 2'd0;
              has_result_o         = 1'b1;
              raw                  = 16'(num_val);
              result_o.chunk_width = qsbp_pkg::W_DIGIT3;
              result_o.last_chunk  = (rem_n == 16'd0);
            end else if (rem_n == 16'd0) begin
              state_o.group_acc    = 7'd0;
              state_o.group_fill   = 2'd0;
              has_result_o         = 1'b1;
              raw                  = 16'(num_val);
              result_o.chunk_width = (fill_n == qsbp_pkg::FILL_TWO) ? qsbp_pkg::W_DIGIT2
                                                                     : qsbp_pkg::W_DIGIT1;
              result_o.last_chunk  = 1'b1;
            end else begin
              state_o.group_acc  = num_val[6:0];
              state_o.group_fill = fill_n;
            end
          end
        end
        qsbp_pkg::MODE_ALNUM: begin
          if (sym > qsbp_pkg::ALNUM_MAX) begin
            bad = 1'b1;
          end else begin
            state_o.remaining = rem_n;
            if (state_i.group_fill != 2'd0) begin
              state_o.group_acc    = 7'd0;
              state_o.group_fill   = 2'd0;
              has_result_o         = 1'b1;
              raw                  = 16'(aln_val);
              result_o.chunk_width = qsbp_pkg::W_ALNUM2;
              result_o.last_chunk  = (rem_n == 16'd0);
            end else if (rem_n == 16'd0) begin
              has_result_o         = 1'b1;
              raw                  = sym;
              result_o.chunk_width = qsbp_pkg::W_ALNUM1;
              result_o.last_chunk  = 1'b1;
            end else begin
              state_o.group_acc  = sym[6:0];
              state_o.group_fill = 2'd1;
            end
          end
        end
        qsbp_pkg::MODE_BYTE: begin
          state_o.remaining    = rem_n;
          has_result_o         = 1'b1;
          raw                  = {8'd0, sym[7:0]};
          result_o.chunk_width = qsbp_pkg::W_BYTE;
          result_o.last_chunk  = (rem_n == 16'd0);
        end
        qsbp_pkg::MODE_KANJI: begin
          if ((sym >= qsbp_pkg::KANJI_LO1 && sym <= qsbp_pkg::KANJI_HI1) ||
              (sym >= qsbp_pkg::KANJI_LO2 && sym <= qsbp_pkg::KANJI_HI2)) begin
            state_o.remaining    = rem_n;
            has_result_o         = 1'b1;
            raw                  = kan_val;
            result_o.chunk_width = qsbp_pkg::W_KANJI;
            result_o.last_chunk  = (rem_n == 16'd0);
          end else begin
            bad = 1'b1;
          end
        end
        default: begin
          bad = 1'b1;
        end
      endcase
    end

    if (bad) begin
      state_o              = state_i;
      has_result_o         = 1'b1;
      raw                  = 16'd0;
      result_o.chunk_width = 5'd0;
      result_o.last_chunk  = 1'b0;
      result_o.error       = 1'b1;
    end

    result_o.chunk_value = raw & qsbp_pkg::chunk_mask(result_o.chunk_width);
  end

endmodule

[design/qsbp_out_reg.sv]
module qsbp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  qsbp_pkg::result_t result_i,
  output logic              free_o,
  qsbp_out_if.source        out_o
);

  logic              valid_q;
  qsbp_pkg::result_t result_q;

  assign free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.chunk_value = result_q.chunk_value;
  assign out_o.chunk_width = result_q.chunk_width;
  assign out_o.last_chunk  = result_q.last_chunk;
  assign out_o.error       = result_q.error;

endmodule

[design/qr_segment_bit_packer_core.sv]
// QR data segment bit packer.
// Input channel in_i carries one transaction per item: a start opens a segment
// and yields the character count header; each valid symbol in it adds a character.
// Output channel out_o carries one chunk per transaction: a right-aligned value
// with its bit width, a flag on the chunk that ends the segment, and an error
// flag for a symbol that is invalid in the open mode.
// An accepted item enters an input register; the encoder and the segment state
// update sit between it and the output register, which drives out_o. A symbol
// that only fills a numeric or alphanumeric group produces no transaction.
// One item is accepted every cycle while the output register is free or being
// drained; the single output register sets that figure.
// Reset closes any open segment and empties both registers.
// When the receiver stalls, the chunk holds on out_o, one more item waits in
// the input register, and in_i.ready drops until the output is taken.
`include "qr_segment_bit_packer_core_defines.svh"

module qr_segment_bit_packer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  qsbp_in_if.sink    in_i,
  qsbp_out_if.source out_o
);

  logic              s1_valid;
  qsbp_pkg::item_t   s1_item;
  logic              s1_move;
  logic              out_free;
  logic              has_result;
  qsbp_pkg::result_t result;
  qsbp_pkg::state_t  state_q;
  qsbp_pkg::state_t  state_d;
  logic              out_err;

  assign s1_move = s1_valid && out_free;
  assign out_err = out_o.valid && out_o.error;

  qsbp_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (s1_move),
    .valid_o   (s1_valid),
    .item_o    (s1_item)
  );

  qsbp_encoder u_encoder (
    .item_i       (s1_item),
    .state_i      (state_q),
    .state_o      (state_d),
    .result_o     (result),
    .has_result_o (has_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (s1_move) begin
      state_q <= state_d;
    end
  end

  qsbp_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (s1_move && has_result),
    .result_i (result),
    .free_o   (out_free),
    .out_o    (out_o)
  );

  `QSBP_ASSERT_SAME(a_idle_group_empty, state_q.remaining == 16'd0, state_q.group_fill == 2'd0)
  `QSBP_ASSERT_SAME(a_fill_bound, 1'b1, state_q.group_fill != qsbp_pkg::FILL_FULL)
  `QSBP_ASSERT_NEXT(a_item_kept, s1_valid && !s1_move, s1_valid)
  `QSBP_ASSERT_SAME(a_error_empty, out_err, out_o.chunk_width == 5'd0 && !out_o.last_chunk)

endmodule

[bench/tb_qr_segment_bit_packer_core.sv]
module tb_qr_segment_bit_packer_core;
  import qsbp_pkg::*;

  logic clk_i;
  logic rst_ni;

  qsbp_in_if  in_bus ();
  qsbp_out_if out_bus ();

  qr_segment_bit_packer_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  typedef struct {
    item_t   stim;
    bit      typed;
    result_t want;
  } dir_row_t;

  dir_row_t dir_tab[$];
  result_t  chunk_q[$];

  mode_e       open_mode  = MODE_NUMERIC;
  logic [15:0] chars_left = '0;
  logic [6:0]  held_val   = '0;
  logic [1:0]  held_cnt   = '0;

  int unsigned send_gap_pct = 11;
  int unsigned stall_pct    = 49;
  int unsigned items_done   = 0;
  int unsigned fail_cnt     = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic bit pack_chunk(input item_t it, output result_t ch);
    logic [4:0]  w;
    logic [9:0]  grp;
    logic [15:0] adj;
    bit          fin;
    ch = '0;
    if (it.operation == OP_START) begin
      w = (it.count_bits > W_MAX) ? W_MAX : it.count_bits;
      open_mode      = mode_e'(it.mode);
      chars_left     = it.char_count;
      held_val       = '0;
      held_cnt       = '0;
      ch.chunk_value = it.char_count & (16'hFFFF >> (W_MAX - w));
      ch.chunk_width = w;
      ch.last_chunk  = (it.char_count == 16'd0);
      return 1'b1;
    end
    if (chars_left == 16'd0) begin
      return 1'b0;
    end
    case (open_mode)
      MODE_NUMERIC: begin
        if (it.symbol > DIGIT_MAX) begin
          ch.error = 1'b1;
          return 1'b1;
        end
        grp        = held_val * DIGIT_RADIX + it.symbol[9:0];
        held_cnt   = held_cnt + 2'd1;
        chars_left = chars_left - 16'd1;
        fin        = (chars_left == 16'd0);
        if (held_cnt == FILL_FULL || fin) begin
          ch.chunk_value = {6'd0, grp};
          ch.chunk_width = (held_cnt == FILL_FULL) ? W_DIGIT3 :
                           (held_cnt == FILL_TWO)  ? W_DIGIT2 : W_DIGIT1;
          ch.last_chunk  = fin;
          held_val       = '0;
          held_cnt       = '0;
          return 1'b1;
        end
        held_val = grp[6:0];
        return 1'b0;
      end
      MODE_ALNUM: begin
        if (it.symbol > ALNUM_MAX) begin
          ch.error = 1'b1;
          return 1'b1;
        end
        chars_left = chars_left - 16'd1;
        fin        = (chars_left == 16'd0);
        if (held_cnt != 2'd0) begin
          ch.chunk_value = held_val * ALNUM_RADIX + it.symbol;
          ch.chunk_width = W_ALNUM2;
          ch.last_chunk  = fin;
          held_val       = '0;
          held_cnt       = '0;
          return 1'b1;
        end
        if (fin) begin
          ch.chunk_value = it.symbol;
          ch.chunk_width = W_ALNUM1;
          ch.last_chunk  = 1'b1;
          return 1'b1;
        end
        held_val = it.symbol[6:0];
        held_cnt = 2'd1;
        return 1'b0;
      end
      MODE_BYTE: begin
        chars_left     = chars_left - 16'd1;
        ch.chunk_value = {8'd0, it.symbol[7:0]};
        ch.chunk_width = W_BYTE;
        ch.last_chunk  = (chars_left == 16'd0);
        return 1'b1;
      end
      default: begin
        if (it.symbol >= KANJI_LO1 && it.symbol <= KANJI_HI1) begin
          adj = it.symbol - KANJI_LO1;
        end else if (it.symbol >= KANJI_LO2 && it.symbol <= KANJI_HI2) begin
          adj = it.symbol - KANJI_OFS2;
        end else begin
          ch.error = 1'b1;
          return 1'b1;
        end
        chars_left     = chars_left - 16'd1;
        ch.chunk_value = adj[15:8] * KANJI_ROW + adj[7:0];
        ch.chunk_width = W_KANJI;
        ch.last_chunk  = (chars_left == 16'd0);
        return 1'b1;
      end
    endcase
  endfunction

  task automatic report_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  task automatic add_start(input mode_e m, input logic [15:0] cnt, input logic [4:0] bits,
                           input logic [15:0] hdr, input logic [4:0] w, input bit fin);
    dir_row_t r;
    r.stim                  = '0;
    r.stim.operation        = OP_START;
    r.stim.mode             = m;
    r.stim.char_count       = cnt;
    r.stim.count_bits       = bits;
    r.typed                 = 1'b1;
    r.want                  = '0;
    r.want.chunk_value      = hdr;
    r.want.chunk_width      = w;
    r.want.last_chunk       = fin;
    dir_tab = {dir_tab, r};
  endtask

  task automatic add_symbol(input logic [15:0] sym, input bit bad);
    dir_row_t r;
    r.stim           = '0;
    r.stim.operation = OP_SYMBOL;
    r.stim.symbol    = sym;
    r.typed          = bad;
    r.want           = '0;
    r.want.error     = bad;
    dir_tab = {dir_tab, r};
  endtask

  task automatic push_item(input item_t it, input bit typed, input result_t want);
    result_t pred;
    bit      has;
    bit      counted;
    while ($urandom_range(99, 0) < send_gap_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.operation  <= it.operation;
    in_bus.mode       <= it.mode;
    in_bus.char_count <= it.char_count;
    in_bus.count_bits <= it.count_bits;
    in_bus.symbol     <= it.symbol;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    counted = (it.operation == OP_START) || (chars_left != 16'd0);
    has     = pack_chunk(it, pred);
    if (has) begin
      chunk_q = {chunk_q, typed ? want : pred};
    end
    if (counted) begin
      items_done++;
    end
  endtask

  task automatic random_segment();
    item_t   it;
    result_t none;
    int      len;
    int      sent;
    bit      bad;
    none          = '0;
    it            = '0;
    it.operation  = OP_START;
    it.mode       = 2'($urandom_range(3, 0));
    it.count_bits = 5'($urandom_range(31, 0));
    if ($urandom_range(9, 0) == 0) begin
      it.char_count = 16'($urandom());
      len           = $urandom_range(6, 0);
    end else begin
      it.char_count = 16'($urandom_range(12, 0));
      len           = it.char_count;
      if (len > 0 && $urandom_range(9, 0) == 0) begin
        len = $urandom_range(len - 1, 0);
      end
    end
    push_item(it, 1'b0, none);
    it.operation = OP_SYMBOL;
    sent         = 0;
    while (sent < len) begin
      bad = ($urandom_range(19, 0) == 0);
      case (mode_e'(it.mode))
        MODE_NUMERIC: begin
          it.symbol = bad ? 16'($urandom_range(65535, 10)) : 16'($urandom_range(9, 0));
        end
        MODE_ALNUM: begin
          it.symbol = bad ? 16'($urandom_range(65535, 45)) : 16'($urandom_range(44, 0));
        end
        MODE_BYTE: begin
          it.symbol = bad ? 16'($urandom()) : 16'($urandom_range(255, 0));
          bad       = 1'b0;
        end
        default: begin
          if (bad) begin
            case ($urandom_range(2, 0))
              0:       it.symbol = 16'($urandom_range(16'h813F, 0));
              1:       it.symbol = 16'($urandom_range(16'hE03F, 16'h9FFD));
              default: it.symbol = 16'($urandom_range(16'hFFFF, 16'hEBC0));
            endcase
          end else if ($urandom_range(1, 0) == 0) begin
            it.symbol = 16'($urandom_range(KANJI_HI1, KANJI_LO1));
          end else begin
            it.symbol = 16'($urandom_range(KANJI_HI2, KANJI_LO2));
          end
        end
      endcase
      push_item(it, 1'b0, none);
      if (!bad) begin
        sent++;
      end
    end
    if ($urandom_range(7, 0) == 0) begin
      it.symbol = 16'($urandom());
      push_item(it, 1'b0, none);
    end
  endtask

  task automatic drain_wait();
    in_bus.valid <= 1'b0;
    while (chunk_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        got.chunk_value = out_bus.chunk_value;
        got.chunk_width = out_bus.chunk_width;
        got.last_chunk  = out_bus.last_chunk;
        got.error       = out_bus.error;
        if (chunk_q.size() == 0) begin
          report_fail($sformatf("unexpected chunk value=%h width=%0d last=%b error=%b",
                                got.chunk_value, got.chunk_width, got.last_chunk,
                                got.error));
        end else begin
          want = chunk_q.pop_front();
          if (got.chunk_value !== want.chunk_value || got.chunk_width !== want.chunk_width ||
              got.last_chunk !== want.last_chunk || got.error !== want.error) begin
            report_fail($sformatf({"chunk mismatch: expected value=%h width=%0d last=%b ",
                                   "error=%b, got value=%h width=%0d last=%b error=%b"},
                                  want.chunk_value, want.chunk_width, want.last_chunk,
                                  want.error, got.chunk_value, got.chunk_width,
                                  got.last_chunk, got.error));
          end
        end
      end
      out_bus.ready <= ($urandom_range(99, 0) >= stall_pct);
    end else begin
      out_bus.ready <= 1'b0;
    end
  end

  initial begin
    rst_ni            <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.operation  <= OP_START;
    in_bus.mode       <= MODE_NUMERIC;
    in_bus.char_count <= '0;
    in_bus.count_bits <= '0;
    in_bus.symbol     <= '0;

    add_symbol(16'h0000, 1'b0);
    add_start(MODE_NUMERIC, 16'd5, 5'd10, 16'd5, 5'd10, 1'b0);
    add_symbol(16'd10, 1'b1);
    add_symbol(16'd0, 1'b0);
    add_symbol(16'd9, 1'b0);
    add_symbol(16'd9, 1'b0);
    add_symbol(16'hFFFF, 1'b1);
    add_symbol(16'd9, 1'b0);
    add_symbol(16'd9, 1'b0);
    add_start(MODE_NUMERIC, 16'd1, 5'd31, 16'd1, 5'd16, 1'b0);
    add_symbol(16'd7, 1'b0);
    add_start(MODE_ALNUM, 16'd3, 5'd0, 16'd0, 5'd0, 1'b0);
    add_symbol(16'd44, 1'b0);
    add_symbol(16'd45, 1'b1);
    add_symbol(16'd44, 1'b0);
    add_symbol(16'd0, 1'b0);
    add_start(MODE_BYTE, 16'hFFFF, 5'd16, 16'hFFFF, 5'd16, 1'b0);
    add_symbol(16'hFFFF, 1'b0);
    add_start(MODE_BYTE, 16'd0, 5'd4, 16'd0, 5'd4, 1'b1);
    add_symbol(16'h0041, 1'b0);
    add_start(MODE_KANJI, 16'h0103, 5'd8, 16'h0003, 5'd8, 1'b0);
    add_symbol(KANJI_LO1, 1'b0);
    add_symbol(16'h8139, 1'b1);
    add_symbol(KANJI_HI1, 1'b0);
    add_symbol(16'hE03F, 1'b1);
    add_symbol(KANJI_LO2, 1'b0);
    add_symbol(KANJI_HI2, 1'b0);
    add_symbol(16'hFFFF, 1'b1);
    add_start(MODE_NUMERIC, 16'd2, 5'd4, 16'd2, 5'd4, 1'b0);
    add_symbol(16'd1, 1'b0);
    add_start(MODE_ALNUM, 16'd1, 5'd9, 16'd1, 5'd9, 1'b0);
    add_symbol(16'd20, 1'b0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      push_item(dir_tab[i].stim, dir_tab[i].typed, dir_tab[i].want);
    end
    while (items_done < 280) random_segment();
    drain_wait();

    send_gap_pct = 49;
    stall_pct    = 11;
    while (items_done < 560) random_segment();
    drain_wait();

    send_gap_pct = 0;
    stall_pct    = 0;
    while (items_done < 850) random_segment();
    drain_wait();
    repeat (8) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[qr_segment_bit_packer_core.f]
+incdir+design
design/qsbp_pkg.sv
design/qsbp_if.sv
design/qsbp_in_reg.sv
design/qsbp_encoder.sv
design/qsbp_out_reg.sv
design/qr_segment_bit_packer_core.sv
bench/tb_qr_segment_bit_packer_core.sv
